// ----- rtl/frm_pkg.sv -----
`default_nettype none

package frm_pkg;

  localparam int COUNT_W = 32;
  localparam int MS_W = 10;
  localparam int MUL_W = COUNT_W + MS_W;
  localparam int RATE_W = 24;
  localparam int PERIOD_W = 16;

  localparam logic [RATE_W-1:0] RATE_MAX = 24'hFFFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFFFFFF;
  localparam logic [MS_W-1:0] MS_PER_S = 10'd1000;
  localparam logic [31:0] GAP_INIT = 32'd10000;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GAP  = 6'b000010,
    S_UPD  = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    DIV_AVG  = 2'd0,
    DIV_LOW  = 2'd1,
    DIV_HIGH = 2'd2
  } div_kind_t;

endpackage

`default_nettype wire

// ----- rtl/frame_rate_meter_unit.sv -----
`default_nettype none

// Frame rate meter. Each input item is a frame event (s_tuser = 0) or a window
// restart (s_tuser = 1) with a millisecond timestamp, and gives exactly one
// output item carrying the current average, minimum and maximum rates (unsigned,
// FRAC_BITS fraction bits, saturated at 0xFFFFFF) with the updated and valid
// flags. The block works on one item at a time. A restart goes from acceptance
// through the gap stage to the output register; a frame that does not close a
// window also passes the update stage. In continuous mode (period_ms = 0) a
// frame also runs the average division, and a frame that closes a window runs
// the average, minimum and maximum divisions. The divisions use the single
// restoring divider, which retires one quotient bit per cycle and is shared
// by the three rate divisions. The output register frees the input side while
// a finished item waits to be taken.
module frame_rate_meter_unit
  import frm_pkg::*;
#(
  parameter int TIME_BITS = 32,
  parameter int FRAC_BITS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wen,
  input  wire logic [15:0]   cfg_wdata,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [31:0]   s_tdata,   // now_ms
  input  wire logic          s_tuser,   // req_type
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [71:0]        m_tdata,   // fps, fps_min, fps_max
  output logic [1:0]         m_tuser    // updated, fps_valid
);

  localparam int NW = MUL_W + FRAC_BITS;
  localparam int SW = $clog2(NW + 1);
  localparam int SHORT_STEPS = MS_W + FRAC_BITS;

  state_t state;
  div_kind_t kind;

  logic [PERIOD_W-1:0] period_ms;
  logic [TIME_BITS-1:0] now_r;
  logic restart_r;
  logic win_r;
  logic upd_r;

  logic [TIME_BITS-1:0] window_start;
  logic [TIME_BITS-1:0] last_time;
  logic [COUNT_W-1:0] frame_count;
  logic [TIME_BITS-1:0] shortest_gap;
  logic [TIME_BITS-1:0] longest_gap;
  logic [TIME_BITS-1:0] gap_r;
  logic [TIME_BITS-1:0] elapsed_r;
  logic [RATE_W-1:0] rate_avg;
  logic [RATE_W-1:0] rate_low;
  logic [RATE_W-1:0] rate_high;
  logic rate_seen;

  logic [NW-1:0] num_sr;
  logic [TIME_BITS-1:0] rem;
  logic [RATE_W-1:0] quo;
  logic ovf;
  logic [SW-1:0] steps;

  logic [TIME_BITS-1:0] den;
  logic [TIME_BITS:0] sh;
  logic [TIME_BITS:0] diff;
  logic ge;
  logic [TIME_BITS-1:0] rem_next;
  logic [RATE_W-1:0] rate_res;
  logic [NW-1:0] short_num;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    unique case (kind)
      DIV_AVG:  den = elapsed_r;
      DIV_LOW:  den = longest_gap;
      DIV_HIGH: den = shortest_gap;
      default:  den = '0;
    endcase
  end

  assign sh = {rem, num_sr[NW-1]};
  assign diff = sh - {1'b0, den};
  assign ge = (sh >= {1'b0, den});
  assign rem_next = ge ? diff[TIME_BITS-1:0] : sh[TIME_BITS-1:0];
  assign rate_res = ((den == '0) || ovf) ? RATE_MAX : quo;
  assign short_num = NW'(MS_PER_S) << (NW - MS_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ms <= PERIOD_RESET;
    end else if (cfg_wen) begin
      period_ms <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      kind <= DIV_AVG;
      m_tvalid <= 1'b0;
      window_start <= '0;
      last_time <= '0;
      frame_count <= '0;
      shortest_gap <= TIME_BITS'(GAP_INIT);
      longest_gap <= '0;
      rate_avg <= '0;
      rate_low <= '0;
      rate_high <= '0;
      rate_seen <= 1'b0;
      steps <= '0;
    end else begin
      if ((state == S_DONE) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            now_r <= TIME_BITS'(s_tdata);
            restart_r <= s_tuser;
            state <= S_GAP;
          end
        end
        S_GAP: begin
          if (restart_r) begin
            window_start <= now_r;
            last_time <= now_r;
            frame_count <= '0;
            shortest_gap <= TIME_BITS'(GAP_INIT);
            longest_gap <= '0;
            rate_avg <= '0;
            rate_low <= '0;
            rate_high <= '0;
            rate_seen <= 1'b0;
            upd_r <= 1'b0;
            state <= S_DONE;
          end else begin
            gap_r <= now_r - last_time;
            elapsed_r <= now_r - window_start;
            last_time <= now_r;
            if (frame_count != COUNT_MAX) begin
              frame_count <= frame_count + 1'b1;
            end
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (gap_r < shortest_gap) begin
            shortest_gap <= gap_r;
          end
          if (gap_r > longest_gap) begin
            longest_gap <= gap_r;
          end
          priority if (period_ms == '0) begin
            win_r <= 1'b0;
            state <= S_MUL;
          end else if (elapsed_r >= TIME_BITS'(period_ms)) begin
            win_r <= 1'b1;
            state <= S_MUL;
          end else begin
            upd_r <= 1'b0;
            state <= S_DONE;
          end
        end
        S_MUL: begin
          num_sr <= NW'(MUL_W'(frame_count) * MUL_W'(MS_PER_S)) << FRAC_BITS;
          rem <= '0;
          quo <= '0;
          ovf <= 1'b0;
          steps <= SW'(NW);
          kind <= DIV_AVG;
          state <= S_DIV;
        end
        S_DIV: begin
          if (steps != '0) begin
            num_sr <= num_sr << 1;
            rem <= rem_next;
            quo <= {quo[RATE_W-2:0], ge};
            ovf <= ovf | quo[RATE_W-1];
            steps <= steps - 1'b1;
          end else begin
            num_sr <= short_num;
            rem <= '0;
            quo <= '0;
            ovf <= 1'b0;
            steps <= SW'(SHORT_STEPS);
            unique case (kind)
              DIV_AVG: begin
                rate_avg <= rate_res;
                if (win_r) begin
                  kind <= DIV_LOW;
                end else begin
                  rate_seen <= 1'b1;
                  upd_r <= 1'b1;
                  state <= S_DONE;
                end
              end
              DIV_LOW: begin
                rate_low <= rate_res;
                kind <= DIV_HIGH;
              end
              default: begin
                rate_high <= rate_res;
                window_start <= now_r;
                frame_count <= '0;
                shortest_gap <= TIME_BITS'(GAP_INIT);
                longest_gap <= '0;
                rate_seen <= 1'b1;
                upd_r <= 1'b1;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {rate_high, rate_low, rate_avg};
            m_tuser <= {rate_seen, upd_r};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("output item raised outside write-back");

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> steps <= SW'(NW))
    else $error("divider step count out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
    else $error("rates reported without a valid measurement");

  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_GAP)
    else $error("accepted item not taken into gap stage");

endmodule

`default_nettype wire
